// ===== design/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
package u16u8_pkg;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    localparam logic [15:0] LIMIT_1B = 16'h0080;
    localparam logic [15:0] LIMIT_2B = 16'h0800;

    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] CONT_B  = 8'h80;

    // One encoded code point: up to four bytes, sent from index 0 to last_idx.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            err;
    } t_group;

endpackage

// ===== design/u16u8_enc.sv =====
// Input register, surrogate pairing state and UTF-8 byte group encoder.
`timescale 1ns / 1ps
module u16u8_enc
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_code_unit,
    output logic        o_ready,
    output logic        o_grp_valid,
    output t_group      o_grp,
    input  logic        i_grp_ready
);

    logic        r_in_valid;
    logic [15:0] r_unit;
    logic        r_high_pending;
    logic [9:0]  r_held_high;

    logic        n_high_pending;
    logic [9:0]  n_held_high;
    logic        is_high;
    logic        is_low;
    logic        has_out;
    logic        advance;
    logic [4:0]  plane;
    logic [20:0] cp;
    t_group      grp;

    assign is_high = r_unit inside {[HIGH_FIRST:HIGH_LAST]};
    assign is_low  = r_unit inside {[LOW_FIRST:LOW_LAST]};

    // 0x10000 + (hb << 10 | lo): the add only touches bits 20:16
    assign plane = {1'b0, r_held_high[9:6]} + 5'd1;
    assign cp    = {plane, r_held_high[5:0], r_unit[9:0]};

    always_comb begin
        grp            = '0;
        has_out        = 1'b1;
        n_high_pending = r_high_pending;
        n_held_high    = r_held_high;
        if (r_high_pending) begin
            n_high_pending = 1'b0;
            n_held_high    = '0;
            if (!is_low) begin
                grp.err = 1'b1;
            end else begin
                grp.bytes[0] = LEAD_4B | {5'd0, cp[20:18]};
                grp.bytes[1] = CONT_B | {2'd0, cp[17:12]};
                grp.bytes[2] = CONT_B | {2'd0, cp[11:6]};
                grp.bytes[3] = CONT_B | {2'd0, cp[5:0]};
                grp.last_idx = 2'd3;
            end
        end else if (is_high) begin
            has_out        = 1'b0;
            n_high_pending = 1'b1;
            n_held_high    = r_unit[9:0];
        end else if (is_low) begin
            grp.err = 1'b1;
        end else if (r_unit < LIMIT_1B) begin
            grp.bytes[0] = r_unit[7:0];
        end else if (r_unit < LIMIT_2B) begin
            grp.bytes[0] = LEAD_2B | {3'd0, r_unit[10:6]};
            grp.bytes[1] = CONT_B | {2'd0, r_unit[5:0]};
            grp.last_idx = 2'd1;
        end else begin
            grp.bytes[0] = LEAD_3B | {4'd0, r_unit[15:12]};
            grp.bytes[1] = CONT_B | {2'd0, r_unit[11:6]};
            grp.bytes[2] = CONT_B | {2'd0, r_unit[5:0]};
            grp.last_idx = 2'd2;
        end
    end

    // a parked high surrogate leaves without waiting on the serializer
    assign advance     = r_in_valid && (!has_out || i_grp_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_grp_valid = r_in_valid && has_out;
    assign o_grp       = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_high_pending <= 1'b0;
            r_held_high    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_high_pending <= n_high_pending;
                r_held_high    <= n_held_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_unit <= i_code_unit;
        end
    end

    a_pending_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_pending && advance |=> !r_high_pending)
        else $error("held high surrogate not released");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_grp_valid && o_grp.err |-> o_grp.last_idx == 2'd0 && o_grp.bytes == '0)
        else $error("error group must be one zero byte");

endmodule

// ===== design/u16u8_ser.sv =====
// Result register that sends a byte group out one byte per request.
`timescale 1ns / 1ps
module u16u8_ser
    import u16u8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_grp_valid,
    input  t_group     i_grp,
    output logic       o_grp_ready,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_is_error,
    output logic       o_last,
    input  logic       i_ready
);

    logic       r_valid;
    t_group     r_grp;
    logic [1:0] r_idx;

    assign o_valid     = r_valid;
    assign o_out_byte  = r_grp.bytes[r_idx];
    assign o_is_error  = r_grp.err;
    assign o_last      = (r_idx == r_grp.last_idx);
    assign o_grp_ready = !r_valid || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_grp_ready) begin
            r_valid <= i_grp_valid;
            r_idx   <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grp_ready && i_grp_valid) begin
            r_grp <= i_grp;
        end
    end

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_error |-> o_last && o_out_byte == 8'd0)
        else $error("error result must be a single zero byte");

    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && i_ready |=> o_valid && r_idx == $past(r_idx) + 2'd1)
        else $error("byte group broken off early");

    a_cont_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_error && r_idx != 2'd0 |-> o_out_byte[7:6] == 2'b10)
        else $error("trailing byte lacks continuation prefix");

endmodule

// ===== design/utf16_to_utf8_encoder.sv =====
// Top level of the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
// Usage
//   Input channel: i_valid / o_ready with one UTF-16 code unit in i_code_unit.
//   Output channel: o_valid / i_ready with one result per request:
//   o_out_byte (UTF-8 byte), o_is_error (bad surrogate sequence, byte is zero)
//   and o_last (final result of that code unit).
//   A high surrogate gives no result; it is parked and paired with the next
//   unit. A valid pair gives four bytes, a BMP unit one to three bytes, and a
//   lone low surrogate or a broken pair gives one error result.
// Flow: a unit taken into the input register is encoded from it and moves
//   into the output register when that is free; its first result is offered after it.
// Throughput: one request per cycle on both sides while i_ready stays high and
//   each unit yields at most one result; the output register sends one byte per
//   cycle, so a multi-byte unit holds it until its last byte is taken and the
//   input side backs up behind it. A high surrogate passes with no result.
// Reset: synchronous active-low i_rst_n empties both registers and drops any
//   parked high surrogate.
// Stall: with i_ready low the current byte holds; the input register still
//   takes units until it holds one with a result, and then o_ready goes low.
module utf16_to_utf8_encoder
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_code_unit,
    output logic        o_ready,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_is_error,
    output logic        o_last,
    input  logic        i_ready
);

    logic   grp_valid;
    logic   grp_ready;
    t_group grp;

    // classify, pair surrogates and build the byte group
    u16u8_enc u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .o_ready     (o_ready),
        .o_grp_valid (grp_valid),
        .o_grp       (grp),
        .i_grp_ready (grp_ready)
    );

    // send the group out byte by byte
    u16u8_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .o_grp_ready (grp_ready),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_is_error  (o_is_error),
        .o_last      (o_last),
        .i_ready     (i_ready)
    );

endmodule

// ===== dv/utf8_stream_checker.sv =====
// Checker for the UTF-16 to UTF-8 encoder: predicts result bytes and compares them.
`timescale 1ns / 1ps
module utf8_stream_checker
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_is_error,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_byte_count,
    output int          o_error_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       fin;
    } utf8_result_t;

    utf8_result_t expected_bytes[$];

    // Surrogate pairing state
    logic       high_parked;
    logic [9:0] parked_bits;

    int fails;
    int bytes_seen;
    int errors_seen;

    function automatic void queue_error();
        expected_bytes.push_back('{data: 8'h00, err: 1'b1, fin: 1'b1});
    endfunction

    function automatic void queue_code_point(input logic [20:0] cp);
        logic [3:0][7:0] seq;
        int              n;
        if (cp < 21'(LIMIT_1B)) begin
            seq[0] = cp[7:0];
            n      = 1;
        end else if (cp < 21'(LIMIT_2B)) begin
            seq[0] = LEAD_2B | {3'b000, cp[10:6]};
            seq[1] = CONT_B | {2'b00, cp[5:0]};
            n      = 2;
        end else if (cp < 21'h10000) begin
            seq[0] = LEAD_3B | {4'h0, cp[15:12]};
            seq[1] = CONT_B | {2'b00, cp[11:6]};
            seq[2] = CONT_B | {2'b00, cp[5:0]};
            n      = 3;
        end else begin
            seq[0] = LEAD_4B | {5'b00000, cp[20:18]};
            seq[1] = CONT_B | {2'b00, cp[17:12]};
            seq[2] = CONT_B | {2'b00, cp[11:6]};
            seq[3] = CONT_B | {2'b00, cp[5:0]};
            n      = 4;
        end
        for (int k = 0; k < n; k++) begin
            expected_bytes.push_back('{data: seq[k], err: 1'b0, fin: (k == n - 1)});
        end
    endfunction

    function automatic void predict_unit(input logic [15:0] u);
        logic is_high;
        logic is_low;
        is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
        is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
        if (high_parked) begin
            high_parked = 1'b0;
            if (is_low) begin
                queue_code_point(21'h10000 + {1'b0, parked_bits, u[9:0]});
            end else begin
                queue_error();
            end
            parked_bits = '0;
        end else if (is_high) begin
            high_parked = 1'b1;
            parked_bits = u[9:0];
        end else if (is_low) begin
            queue_error();
        end else begin
            queue_code_point({5'b00000, u});
        end
    endfunction

    always @(posedge i_clk) begin
        utf8_result_t want;
        logic         bad;
        if (!i_rst_n) begin
            high_parked = 1'b0;
            parked_bits = '0;
            expected_bytes.delete();
            fails       = 0;
            bytes_seen  = 0;
            errors_seen = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_unit(i_code_unit);
            end
            if (i_out_valid && i_out_ready) begin
                if (i_is_error === 1'b1) errors_seen++;
                else bytes_seen++;
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result: byte=%h err=%b last=%b", $time,
                             i_out_byte, i_is_error, i_last);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    bad  = 1'b0;
                    if (i_out_byte !== want.data) bad = 1'b1;
                    if (i_is_error !== want.err)  bad = 1'b1;
                    if (i_last !== want.fin)      bad = 1'b1;
                    if (bad) begin
                        $display({"%0t: mismatch: expected byte=%h err=%b last=%b,",
                                  " got byte=%h err=%b last=%b"},
                                 $time, want.data, want.err, want.fin,
                                 i_out_byte, i_is_error, i_last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= expected_bytes.size();
        o_byte_count  <= bytes_seen;
        o_error_count <= errors_seen;
    end

endmodule

// ===== dv/utf16_to_utf8_encoder_tb.sv =====
// Testbench top for the UTF-16 to UTF-8 encoder: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module utf16_to_utf8_encoder_tb;
    import u16u8_pkg::*;

    // 24 directed units come first, so the run totals about 310 units.
    localparam int RANDOM_UNITS = 286;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [15:0] i_code_unit = 16'h0000;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_is_error;
    logic        o_last;

    int fail_count;
    int pending;
    int byte_count;
    int error_count;
    int units_sent = 0;
    int pairs_sent = 0;
    int cycle_count = 0;

    // When set, neither side inserts gaps: back-to-back traffic.
    logic steady = 1'b0;

    always #2 i_clk = ~i_clk;

    utf16_to_utf8_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_is_error  (o_is_error),
        .o_last      (o_last),
        .i_ready     (i_ready)
    );

    utf8_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_code_unit   (i_code_unit),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_byte    (o_out_byte),
        .i_is_error    (o_is_error),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_byte_count  (byte_count),
        .o_error_count (error_count)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("utf16_to_utf8_encoder_tb NOT OK");
            $finish;
        end
    end

    // Output side: unless steady, a fresh random stall before every request is taken.
    // Valid is sampled before the edge's updates, so ready high plus valid
    // seen here means the request was taken at this edge.
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    // One request on the input side. Valid only drops when a gap is drawn,
    // so back-to-back requests never see a low/high pair in one time step.
    task automatic send_unit(input logic [15:0] u);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= u;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        units_sent++;
    endtask

    // Non-surrogate unit: a quarter 1-byte, a quarter 2-byte and half 3-byte encodings.
    function automatic logic [15:0] random_bmp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] random_high();
        return HIGH_FIRST + 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] random_low();
        return LOW_FIRST + 16'($urandom_range(0, 1023));
    endfunction

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int iter;
        int random_goal;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: encoding-length boundaries around 0x80, 0x800 and the
        // surrogate block, including the all-zero unit.
        send_unit(16'h0000);
        send_unit(16'h007F);
        send_unit(16'h0080);
        send_unit(16'h07FF);
        send_unit(16'h0800);
        send_unit(16'hD7FF);
        send_unit(16'hE000);
        send_unit(16'hFFFF);
        // Lowest and highest supplementary code points.
        send_unit(HIGH_FIRST);
        send_unit(LOW_FIRST);
        send_unit(HIGH_LAST);
        send_unit(LOW_LAST);
        // Lone low surrogates at both ends of the range.
        send_unit(LOW_FIRST);
        send_unit(LOW_LAST);
        // Broken pairs: high then high, high then ASCII, high then zero.
        // The second unit is dropped each time.
        send_unit(HIGH_FIRST);
        send_unit(HIGH_LAST);
        send_unit(16'hD83D);
        send_unit(16'h0041);
        send_unit(16'hDA00);
        send_unit(16'h0000);
        // Mixed-corner pairs.
        send_unit(HIGH_FIRST);
        send_unit(LOW_LAST);
        send_unit(HIGH_LAST);
        send_unit(LOW_FIRST);

        // Random: mostly well-formed pairs and BMP text, the rest noise and
        // broken sequences. Every 50 iterations ends with a gap-free stretch.
        random_goal = units_sent + RANDOM_UNITS;
        iter = 0;
        while (units_sent < random_goal) begin
            steady = ((iter % 50) >= 40);
            if (iter == 100) begin
                // Hold off until the output side has drained completely.
                i_valid <= 1'b0;
                wait_drained();
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    send_unit(random_high());
                    send_unit(random_low());
                    pairs_sent++;
                end
                9, 10, 11, 12, 13, 14: send_unit(random_bmp());
                15: send_unit(random_low());
                16: begin
                    send_unit(random_high());
                    send_unit(random_bmp());
                end
                17: begin
                    send_unit(random_high());
                    send_unit(random_high());
                end
                default: send_unit(16'($urandom_range(0, 16'hFFFF)));
            endcase
            iter++;
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        // Drain, then keep the clock running so any stray result would show.
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d code units (%0d random surrogate pairs).", units_sent, pairs_sent);
        $display("Checked %0d UTF-8 bytes and %0d error results.", byte_count, error_count);
        if (fail_count == 0) begin
            $display("utf16_to_utf8_encoder_tb OK");
        end else begin
            $display("utf16_to_utf8_encoder_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== utf16_to_utf8_encoder.f =====
design/u16u8_pkg.sv
design/u16u8_enc.sv
design/u16u8_ser.sv
design/utf16_to_utf8_encoder.sv
dv/utf8_stream_checker.sv
dv/utf16_to_utf8_encoder_tb.sv
